// ----- rtl/stni_pkg.sv -----
// ----------------------------------------------------------------------------
// stni_pkg
// Shared constants and types for the sorted table nearest index block.
// ----------------------------------------------------------------------------
package stni_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

// ----- rtl/stni_req_if.sv -----
// ----------------------------------------------------------------------------
// stni_req_if
// Request channel: load or query requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface stni_req_if
    import stni_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output action, output entry_index, output value,
                    input ready);
    modport sink   (input valid, input action, input entry_index, input value,
                    output ready);
endinterface

// ----- rtl/stni_rsp_if.sv -----
// ----------------------------------------------------------------------------
// stni_rsp_if
// Response channel: nearest index results with valid/ready handshake.
// ----------------------------------------------------------------------------
interface stni_rsp_if
    import stni_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] nearest_index;

    modport source (output valid, output nearest_index, input ready);
    modport sink   (input valid, input nearest_index, output ready);
endinterface

// ----- rtl/stni_table_ram.sv -----
// ----------------------------------------------------------------------------
// stni_table_ram
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stni_table_ram
    import stni_pkg::*;
(
    input  logic             clk,
    input  ram_wr_t          wr,
    input  ram_rd_t          rd,
    output logic [VAL_W-1:0] rd_data
);

    logic [VAL_W-1:0] mem [TABLE_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/stni_ctrl.sv -----
// ----------------------------------------------------------------------------
// stni_ctrl
// Request sequencer: table loads, lower-bound binary search over the
// table memory, neighbor distance compare and the response register.
// ----------------------------------------------------------------------------
module stni_ctrl
    import stni_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] entry_count,
    stni_req_if.sink         req,
    stni_rsp_if.source       rsp,
    output ram_wr_t          ram_wr,
    output ram_rd_t          ram_rd,
    input  logic [VAL_W-1:0] ram_rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_LO_RD,
        ST_LO_CMP,
        ST_HI_CMP,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        first_reg;
    logic [CNT_W-1:0]        len_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [VAL_W-1:0] want_reg;
    logic [VAL_W:0]          dist_lo_reg;
    logic [IDX_W-1:0]        res_reg;
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_index_reg;

    logic                    req_acc;
    logic [CNT_W-1:0]        count_sat;
    logic [CNT_W-1:0]        half;
    logic [CNT_W-1:0]        mid;
    logic                    entry_lt;
    logic [CNT_W-1:0]        first_next;
    logic [CNT_W-1:0]        len_next;
    logic [CNT_W-1:0]        count_m1;
    logic [CNT_W-1:0]        first_m1;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          dist_abs;
    logic                    out_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign count_sat = (entry_count > DEPTH_CNT) ? DEPTH_CNT : entry_count;

    assign half     = len_reg >> 1;
    assign mid      = first_reg + half;
    assign entry_lt = $signed(ram_rd_data) < want_reg;
    assign count_m1 = count_reg - CNT_W'(1);
    assign first_m1 = first_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (entry_lt)
        begin
            first_next = mid + CNT_W'(1);
            len_next   = len_reg - half - CNT_W'(1);
        end
        else
        begin
            first_next = first_reg;
            len_next   = half;
        end
    end

    // absolute distance between query and current read data
    always_comb
    begin
        diff     = {want_reg[VAL_W-1], want_reg}
                 - {ram_rd_data[VAL_W-1], $signed(ram_rd_data)};
        dist_abs = diff[VAL_W] ? (VAL_W+1)'(0) - diff : diff;
    end

    always_comb
    begin
        ram_wr.en   = req_acc && (req.action == ACT_LOAD);
        ram_wr.addr = req.entry_index;
        ram_wr.data = req.value;
    end

    always_comb
    begin
        ram_rd.en   = 1'b0;
        ram_rd.addr = mid[IDX_W-1:0];
        unique case (state_reg)
            ST_RD:
            begin
                ram_rd.en   = 1'b1;
                ram_rd.addr = mid[IDX_W-1:0];
            end
            ST_LO_RD:
            begin
                ram_rd.en   = 1'b1;
                ram_rd.addr = first_m1[IDX_W-1:0];
            end
            ST_LO_CMP:
            begin
                ram_rd.en   = 1'b1;
                ram_rd.addr = first_reg[IDX_W-1:0];
            end
            default:
            begin
                ram_rd.en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            want_reg      <= '0;
            dist_lo_reg   <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_acc && (req.action == ACT_QUERY))
                    begin
                        want_reg  <= req.value;
                        count_reg <= count_sat;
                        first_reg <= '0;
                        len_reg   <= count_sat;
                        if (count_sat == '0)
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    first_reg <= first_next;
                    len_reg   <= len_next;
                    if (len_next != '0)
                    begin
                        state_reg <= ST_RD;
                    end
                    else if (first_next == '0)
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else if (first_next >= count_reg)
                    begin
                        res_reg   <= count_m1[IDX_W-1:0];
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_LO_RD;
                    end
                end
                ST_LO_RD:
                begin
                    state_reg <= ST_LO_CMP;
                end
                ST_LO_CMP:
                begin
                    dist_lo_reg <= dist_abs;
                    state_reg   <= ST_HI_CMP;
                end
                ST_HI_CMP:
                begin
                    // tie goes to the upper neighbor
                    res_reg   <= (dist_lo_reg < dist_abs) ? first_m1[IDX_W-1:0]
                                                          : first_reg[IDX_W-1:0];
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.nearest_index = out_index_reg;

endmodule

// ----- rtl/sorted_table_nearest_index.sv -----
// ----------------------------------------------------------------------------
// sorted_table_nearest_index
// Nearest entry lookup in a sorted table of signed Q16.16 values.
// ----------------------------------------------------------------------------
// Channels: req carries action, entry_index and value; rsp carries
// nearest_index. Both use valid/ready, a request moves when both are high.
// A load request writes one table entry in the cycle it is accepted and
// gives no response. A query request runs a lower-bound binary search in
// the table memory, one read and one compare per halving step (at most
// nine steps for 256 entries); unless the search ends at either end of
// the table, it then reads both neighbors and compares distances. The
// sequencer is idle again in the same cycle the query response turns
// valid, and a load leaves it idle. One request is in work at a time:
// req.ready is high only while the sequencer is idle. The response sits
// in an output register; a new request is accepted while it waits. If
// rsp.ready stays low, the next query holds in its final state until the
// register frees.
// entry_count is written via cfg_we/cfg_wdata; the user must do so only
// while no request is in work, the block does not enforce it. Reset clears
// entry_count and the sequencer; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_nearest_index
    import stni_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    stni_req_if.sink         req,
    stni_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    logic [CNT_W-1:0] entry_count_reg;
    ram_wr_t          ram_wr;
    ram_rd_t          ram_rd;
    logic [VAL_W-1:0] ram_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    stni_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .req         (req),
        .rsp         (rsp),
        .ram_wr      (ram_wr),
        .ram_rd      (ram_rd),
        .ram_rd_data (ram_rd_data)
    );

    stni_table_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rd_data)
    );

    // response index stays inside the table in use
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (entry_count_reg == '0)
                   || ({1'b0, rsp.nearest_index} < entry_count_reg))
        else $error("nearest_index outside table");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr.en |-> !ram_rd.en)
        else $error("table write during search read");

    a_busy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd.en |=> !req.ready)
        else $error("request accepted mid search");

endmodule
